@@ hw/rtl/tlsd_pkg.sv @@
// Package for the type/length string decoder: codes, queue entry type and
// character tables. No dependencies.
package tlsd_pkg;

   // header type field (bits 7:6)
   localparam logic [1:0] TYPE_UNICODE = 2'd0;
   localparam logic [1:0] TYPE_BCD     = 2'd1;
   localparam logic [1:0] TYPE_SIX     = 2'd2;
   localparam logic [1:0] TYPE_ASCII8  = 2'd3;

   // reported string type
   localparam logic [1:0] STYPE_ASCII   = 2'd0;
   localparam logic [1:0] STYPE_UNICODE = 2'd1;
   localparam logic [1:0] STYPE_BINARY  = 2'd2;

   // configuration register indexes
   localparam logic [1:0] CSR_FRU_SEMANTICS = 2'd0;
   localparam logic [1:0] CSR_FORCE_UNICODE = 2'd1;
   localparam logic [1:0] CSR_OUTPUT_LIMIT  = 2'd2;

   localparam logic [7:0] OUTPUT_LIMIT_RESET = 8'd255;

   // bits of the 6-bit stream already taken from the previous byte
   localparam logic [2:0] PHASE_0 = 3'd0;
   localparam logic [2:0] PHASE_4 = 3'd4;
   localparam logic [2:0] PHASE_6 = 3'd6;

   localparam int TLSD_QUEUE_DEPTH = 2;

   typedef enum logic [1:0] {
      KIND_NONE = 2'd0,
      KIND_RAW  = 2'd1,
      KIND_BCD  = 2'd2,
      KIND_SIX  = 2'd3
   } tlsd_kind_type;

   // one queue entry: one or two results of one input beat
   typedef struct packed {
      logic          two;
      tlsd_kind_type kind;
      logic [7:0]    code0;
      logic [7:0]    code1;
      logic          last0;
      logic          last1;
      logic [5:0]    cnt0;
      logic [5:0]    cnt1;
      logic [1:0]    stype;
      logic          err;
   } tlsd_entry_type;

   function automatic logic [7:0] tlsd_bcd_char(input logic [3:0] code);
      logic [7:0] ch;
      case (code)
         4'd10:   ch = 8'h20; // ' '
         4'd11:   ch = 8'h2d; // '-'
         4'd12:   ch = 8'h2e; // '.'
         4'd13:   ch = 8'h3a; // ':'
         4'd14:   ch = 8'h2c; // ','
         4'd15:   ch = 8'h5f; // '_'
         default: ch = 8'h30 + {4'd0, code};
      endcase
      return ch;
   endfunction

   function automatic logic [7:0] tlsd_decode_char(input tlsd_kind_type kind,
                                                   input logic [7:0] code);
      logic [7:0] ch;
      case (kind)
         KIND_RAW: ch = code;
         KIND_BCD: ch = tlsd_bcd_char(code[3:0]);
         KIND_SIX: ch = 8'h20 + {2'd0, code[5:0]}; // 6-bit table is ASCII 0x20..0x5f
         default:  ch = 8'h00;
      endcase
      return ch;
   endfunction

endpackage

@@ hw/rtl/tlsd_front.sv @@
// Front end: config registers, header length check and byte unpacking into
// queue entries. Uses tlsd_pkg.
module tlsd_front import tlsd_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           csr_we,
   input  logic [1:0]     csr_index,
   input  logic [7:0]     csr_wdata,
   input  logic           req_valid,
   output logic           req_ready,
   input  logic           req_is_header,
   input  logic [7:0]     req_data_byte,
   input  logic [10:0]    req_avail_bytes,
   input  logic           q_full,
   output logic           q_push,
   output tlsd_entry_type q_entry
);

   logic       fru_ff, fru_in;
   logic       force_ff, force_in;
   logic [7:0] limit_ff, limit_in;

   logic       active_ff, active_in;
   logic [1:0] cur_type_ff, cur_type_in;
   logic [5:0] chars_left_ff, chars_left_in;
   logic [2:0] phase_ff, phase_in;
   logic [3:0] pending_ff, pending_in;
   logic [5:0] chars_done_ff, chars_done_in;
   logic [1:0] type_report_ff, type_report_in;

   logic        accept;
   logic [1:0]  hdr_type;
   logic [1:0]  hdr_stype;
   logic [5:0]  len;
   logic [10:0] data_cnt;
   logic [7:0]  len3;
   logic        too_long;
   logic        empty_in;
   logic [5:0]  left1, left2, done1, done2;

   assign req_ready = !q_full;
   assign accept    = req_valid && req_ready;

   always_comb begin
      fru_in   = fru_ff;
      force_in = force_ff;
      limit_in = limit_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_FRU_SEMANTICS: fru_in   = csr_wdata[0];
            CSR_FORCE_UNICODE: force_in = csr_wdata[0];
            CSR_OUTPUT_LIMIT:  limit_in = csr_wdata;
            default: ;
         endcase
      end
   end

   // header classification; packed 6-bit capacity is floor(8*data/6),
   // so len > cap is the same as 3*len > 4*data
   assign len      = req_data_byte[5:0];
   assign data_cnt = req_avail_bytes - 11'd1;
   assign len3     = {2'd0, len} + {1'b0, len, 1'b0};
   assign empty_in = (limit_ff == 8'd0) || (req_avail_bytes == 11'd0);

   always_comb begin
      hdr_type = req_data_byte[7:6];
      if (force_ff && hdr_type == TYPE_ASCII8) begin
         hdr_type = TYPE_UNICODE;
      end
      hdr_stype = STYPE_ASCII;
      case (hdr_type)
         TYPE_UNICODE: begin
            hdr_stype = fru_ff ? STYPE_BINARY : STYPE_UNICODE;
            too_long  = {5'd0, len} > data_cnt;
         end
         TYPE_BCD: too_long = {6'd0, len} > {data_cnt, 1'b0};
         TYPE_SIX: too_long = {5'd0, len3} > {data_cnt, 2'b00};
         default:  too_long = {5'd0, len} > data_cnt;
      endcase
      if ({2'd0, len} > limit_ff) begin
         too_long = 1'b1;
      end
   end

   assign left1 = chars_left_ff - 6'd1;
   assign left2 = chars_left_ff - 6'd2;
   assign done1 = chars_done_ff + 6'd1;
   assign done2 = chars_done_ff + 6'd2;

   always_comb begin
      active_in      = active_ff;
      cur_type_in    = cur_type_ff;
      chars_left_in  = chars_left_ff;
      phase_in       = phase_ff;
      pending_in     = pending_ff;
      chars_done_in  = chars_done_ff;
      type_report_in = type_report_ff;
      q_push         = 1'b0;
      q_entry        = '0;
      q_entry.kind   = KIND_NONE;
      q_entry.last0  = 1'b1;

      if (accept) begin
         if (req_is_header) begin
            active_in     = 1'b0;
            chars_left_in = 6'd0;
            chars_done_in = 6'd0;
            phase_in      = PHASE_0;
            pending_in    = 4'd0;
            if (empty_in) begin
               type_report_in = STYPE_ASCII;
               q_push         = 1'b1;
            end else begin
               cur_type_in    = hdr_type;
               type_report_in = hdr_stype;
               q_entry.stype  = hdr_stype;
               if (too_long) begin
                  q_entry.err = 1'b1;
                  q_push      = 1'b1;
               end else if (len == 6'd0) begin
                  q_push = 1'b1;
               end else begin
                  chars_left_in = len;
                  active_in     = 1'b1;
               end
            end
         end else if (active_ff) begin
            q_push        = 1'b1;
            q_entry.stype = type_report_ff;
            q_entry.cnt0  = done1;
            q_entry.cnt1  = done2;
            q_entry.last0 = (left1 == 6'd0);
            q_entry.last1 = (left2 == 6'd0);
            case (cur_type_ff)
               TYPE_BCD: begin
                  q_entry.kind  = KIND_BCD;
                  q_entry.code0 = {4'd0, req_data_byte[3:0]};
                  q_entry.code1 = {4'd0, req_data_byte[7:4]};
                  q_entry.two   = (left1 != 6'd0);
               end
               TYPE_SIX: begin
                  q_entry.kind = KIND_SIX;
                  case (phase_ff)
                     PHASE_0: begin
                        q_entry.code0 = {2'd0, req_data_byte[5:0]};
                        pending_in    = {2'd0, req_data_byte[7:6]};
                        phase_in      = PHASE_6;
                     end
                     PHASE_6: begin
                        q_entry.code0 = {2'd0, req_data_byte[3:0], pending_ff[1:0]};
                        pending_in    = req_data_byte[7:4];
                        phase_in      = PHASE_4;
                     end
                     default: begin
                        q_entry.code0 = {2'd0, req_data_byte[1:0], pending_ff};
                        q_entry.code1 = {2'd0, req_data_byte[7:2]};
                        q_entry.two   = (left1 != 6'd0);
                        pending_in    = 4'd0;
                        phase_in      = PHASE_0;
                     end
                  endcase
               end
               default: begin
                  q_entry.kind  = KIND_RAW;
                  q_entry.code0 = req_data_byte;
               end
            endcase
            chars_left_in = q_entry.two ? left2 : left1;
            chars_done_in = q_entry.two ? done2 : done1;
            active_in     = (chars_left_in != 6'd0);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fru_ff         <= 1'b0;
         force_ff       <= 1'b0;
         limit_ff       <= OUTPUT_LIMIT_RESET;
         active_ff      <= 1'b0;
         cur_type_ff    <= TYPE_UNICODE;
         chars_left_ff  <= 6'd0;
         phase_ff       <= PHASE_0;
         pending_ff     <= 4'd0;
         chars_done_ff  <= 6'd0;
         type_report_ff <= STYPE_ASCII;
      end else begin
         fru_ff         <= fru_in;
         force_ff       <= force_in;
         limit_ff       <= limit_in;
         active_ff      <= active_in;
         cur_type_ff    <= cur_type_in;
         chars_left_ff  <= chars_left_in;
         phase_ff       <= phase_in;
         pending_ff     <= pending_in;
         chars_done_ff  <= chars_done_in;
         type_report_ff <= type_report_in;
      end
   end

endmodule

@@ hw/rtl/tlsd_queue.sv @@
// Small FIFO of decoded entries between front and back end.
// Uses tlsd_pkg for the entry type.
module tlsd_queue import tlsd_pkg::*; #(
   parameter int Depth = TLSD_QUEUE_DEPTH
) (
   input  logic           clock,
   input  logic           reset,
   input  logic           push,
   input  tlsd_entry_type push_entry,
   input  logic           pop,
   output tlsd_entry_type head,
   output logic           empty,
   output logic           full
);

   localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int CntW = $clog2(Depth + 1);
   localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
   localparam logic [CntW-1:0] DepthCnt = CntW'(Depth);

   tlsd_entry_type slots_ff [Depth];
   logic [PtrW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0] count_ff, count_in;

   assign empty = (count_ff == '0);
   assign full  = (count_ff == DepthCnt);
   assign head  = slots_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LastPtr) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LastPtr) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slots_ff[wr_ptr_ff] <= push_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> !full || pop)
      else $error("queue push while full");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> !empty)
      else $error("queue pop while empty");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= DepthCnt)
      else $error("queue count beyond depth");

endmodule

@@ hw/rtl/tlsd_back.sv @@
// Back end: expands queue entries into one result beat per cycle while rsp_ready
// holds nothing back, through the character tables, into a registered result channel. Uses tlsd_pkg.
module tlsd_back import tlsd_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  tlsd_entry_type head,
   input  logic           q_empty,
   output logic           q_pop,
   output logic           rsp_valid,
   input  logic           rsp_ready,
   output logic           rsp_char_valid,
   output logic [7:0]     rsp_out_char,
   output logic           rsp_last_of_string,
   output logic [1:0]     rsp_string_type,
   output logic           rsp_decode_error,
   output logic [5:0]     rsp_char_count
);

   logic       valid_ff, valid_in;
   logic       sel_ff, sel_in;   // second result of the head entry is next
   logic       char_valid_ff;
   logic [7:0] out_char_ff;
   logic       last_ff;
   logic [1:0] stype_ff;
   logic       err_ff;
   logic [5:0] count_ff;
   logic       load;
   logic [7:0] code;

   assign load  = !q_empty && (!valid_ff || rsp_ready);
   assign q_pop = load && (sel_ff || !head.two);
   assign code  = sel_ff ? head.code1 : head.code0;

   always_comb begin
      valid_in = valid_ff;
      sel_in   = sel_ff;
      if (load) begin
         valid_in = 1'b1;
         sel_in   = !q_pop;
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         sel_ff   <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         sel_ff   <= sel_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         char_valid_ff <= (head.kind != KIND_NONE);
         out_char_ff   <= tlsd_decode_char(head.kind, code);
         last_ff       <= sel_ff ? head.last1 : head.last0;
         stype_ff      <= head.stype;
         err_ff        <= head.err;
         count_ff      <= sel_ff ? head.cnt1 : head.cnt0;
      end
   end

   assign rsp_valid          = valid_ff;
   assign rsp_char_valid     = char_valid_ff;
   assign rsp_out_char       = out_char_ff;
   assign rsp_last_of_string = last_ff;
   assign rsp_string_type    = stype_ff;
   assign rsp_decode_error   = err_ff;
   assign rsp_char_count     = count_ff;

   a_err_no_char: assert property (@(posedge clock) disable iff (reset)
      valid_ff && err_ff |-> !char_valid_ff && last_ff && count_ff == 6'd0)
      else $error("error beat carries a character");

   a_second_pops: assert property (@(posedge clock) disable iff (reset)
      load && sel_ff |-> q_pop)
      else $error("second result did not retire its entry");

   a_sel_needs_entry: assert property (@(posedge clock) disable iff (reset)
      sel_ff |-> !q_empty)
      else $error("pending second result without entry");

endmodule

@@ hw/rtl/ipmi_type_length_string_decoder.sv @@
// Type/length string decoder, top level. A result beat is registered in the
// queue and then in the result register. Throughput: one input beat per cycle
// while each causes at most one result and rsp_ready holds no result back; a
// byte that unpacks to two characters holds the single result register for
// both; the queue takes further beats meanwhile until full. Reset (synchronous)
// clears the queue, the decode state and the registers (output_limit to 255).
module ipmi_type_length_string_decoder import tlsd_pkg::*; #(
   parameter int QueueDepth = TLSD_QUEUE_DEPTH
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [7:0]  csr_wdata,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_is_header,
   input  logic [7:0]  req_data_byte,
   input  logic [10:0] req_avail_bytes,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_char_valid,
   output logic [7:0]  rsp_out_char,
   output logic        rsp_last_of_string,
   output logic [1:0]  rsp_string_type,
   output logic        rsp_decode_error,
   output logic [5:0]  rsp_char_count
);

   tlsd_entry_type push_entry;
   tlsd_entry_type head;
   logic           q_push, q_pop, q_empty, q_full;

   tlsd_front u_front (
      .clock           (clock),
      .reset           (reset),
      .csr_we          (csr_we),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_is_header   (req_is_header),
      .req_data_byte   (req_data_byte),
      .req_avail_bytes (req_avail_bytes),
      .q_full          (q_full),
      .q_push          (q_push),
      .q_entry         (push_entry)
   );

   tlsd_queue #(
      .Depth (QueueDepth)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_entry (push_entry),
      .pop        (q_pop),
      .head       (head),
      .empty      (q_empty),
      .full       (q_full)
   );

   tlsd_back u_back (
      .clock              (clock),
      .reset              (reset),
      .head               (head),
      .q_empty            (q_empty),
      .q_pop              (q_pop),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_char_valid     (rsp_char_valid),
      .rsp_out_char       (rsp_out_char),
      .rsp_last_of_string (rsp_last_of_string),
      .rsp_string_type    (rsp_string_type),
      .rsp_decode_error   (rsp_decode_error),
      .rsp_char_count     (rsp_char_count)
   );

endmodule
